/* sv/so3aerc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3aerc_pkg
// Shared types, stage indexes and rounding/saturation helpers for the SO(3)
// attitude error and rate command pipeline.
// ----------------------------------------------------------------------------
package so3aerc_pkg;

  // pipeline stages, in order
  localparam int NSTG   = 7;
  localparam int S_PROD = 0;  // quaternion component products
  localparam int S_MAT  = 1;  // rotation matrix entries, Q24
  localparam int S_XP   = 2;  // matrix entry cross products, Q48
  localparam int S_SUM  = 3;  // entries of Rd^T R
  localparam int S_ERR  = 4;  // attitude error, Q14 saturated
  localparam int S_GAIN = 5;  // gain product, Q22
  localparam int S_OUT  = 6;  // output register

  localparam int NPAIR = 6;   // off-diagonal entries of Rd^T R that are used

  typedef logic signed [15:0] quat_t;
  typedef logic signed [31:0] qprod_t;
  typedef logic signed [33:0] mat_raw_t;   // Q28, exact
  typedef logic signed [29:0] mat_ent_t;   // Q24
  typedef mat_ent_t mat_t [3][3];
  typedef logic signed [57:0] xprod_t;
  typedef logic signed [59:0] asum_t;
  typedef logic signed [15:0] err_t;
  typedef logic signed [23:0] rate_t;
  typedef logic [15:0] gain_t;
  typedef logic signed [33:0] gprod_t;     // Q22

  typedef struct packed {
    logic [NSTG-1:0] ld;
  } stg_ctl_t;

  localparam logic [15:0] GAIN_RST = 16'd512;
  localparam mat_raw_t ONE_Q28 = 34'sd268435456;

  // entry (row, col) of A = Rd^T R; pairs (0,1), (2,3), (4,5) give e_x, e_y, e_z
  localparam logic [1:0] A_ROW [NPAIR] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};
  localparam logic [1:0] A_COL [NPAIR] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};

  // Q28 -> Q24, round half up
  function automatic mat_ent_t mat_round(input mat_raw_t t);
    mat_raw_t s;
    s = t + 34'sd8;
    return s[33:4];
  endfunction

  function automatic err_t sat16(input logic signed [25:0] v);
    err_t r;
    if (v > 26'sd32767) r = 16'sh7fff;
    else if (v < -26'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic rate_t sat24(input logic signed [25:0] v);
    rate_t r;
    if (v > 26'sd8388607) r = 24'sh7fffff;
    else if (v < -26'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

/* sv/so3aerc_quat_mat.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3aerc_quat_mat
// Quaternion to rotation matrix, two stages: component products, then
// matrix entries rounded to Q24.
// ----------------------------------------------------------------------------
module so3aerc_quat_mat
  import so3aerc_pkg::*;
(
  input  logic     clk,
  input  stg_ctl_t ctl,
  input  quat_t    qw,
  input  quat_t    qx,
  input  quat_t    qy,
  input  quat_t    qz,
  output mat_t     m
);

  qprod_t xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  mat_t   m_r, m_nxt;

  always_ff @(posedge clk) begin
    if (ctl.ld[S_PROD]) begin
      xx_r <= 32'(qx) * 32'(qx);
      yy_r <= 32'(qy) * 32'(qy);
      zz_r <= 32'(qz) * 32'(qz);
      xy_r <= 32'(qx) * 32'(qy);
      xz_r <= 32'(qx) * 32'(qz);
      yz_r <= 32'(qy) * 32'(qz);
      wx_r <= 32'(qw) * 32'(qx);
      wy_r <= 32'(qw) * 32'(qy);
      wz_r <= 32'(qw) * 32'(qz);
    end
  end

  always_comb begin
    m_nxt[0][0] = mat_round(ONE_Q28 - ((34'(yy_r) + 34'(zz_r)) <<< 1));
    m_nxt[0][1] = mat_round((34'(xy_r) - 34'(wz_r)) <<< 1);
    m_nxt[0][2] = mat_round((34'(xz_r) + 34'(wy_r)) <<< 1);
    m_nxt[1][0] = mat_round((34'(xy_r) + 34'(wz_r)) <<< 1);
    m_nxt[1][1] = mat_round(ONE_Q28 - ((34'(xx_r) + 34'(zz_r)) <<< 1));
    m_nxt[1][2] = mat_round((34'(yz_r) - 34'(wx_r)) <<< 1);
    m_nxt[2][0] = mat_round((34'(xz_r) - 34'(wy_r)) <<< 1);
    m_nxt[2][1] = mat_round((34'(yz_r) + 34'(wx_r)) <<< 1);
    m_nxt[2][2] = mat_round(ONE_Q28 - ((34'(xx_r) + 34'(yy_r)) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[S_MAT]) begin
      m_r <= m_nxt;
    end
  end

  assign m = m_r;

endmodule

/* sv/so3aerc_err.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3aerc_err
// Attitude error vee(Rd^T R - R^T Rd)/2: cross products, three-term sums,
// then difference, rounding from Q48 to Q14 (halving included) and saturation.
// ----------------------------------------------------------------------------
module so3aerc_err
  import so3aerc_pkg::*;
(
  input  logic     clk,
  input  stg_ctl_t ctl,
  input  mat_t     r,
  input  mat_t     rd,
  output err_t     err [3]
);

  xprod_t xp_r   [NPAIR][3];
  xprod_t xp_nxt [NPAIR][3];
  asum_t  as_r   [NPAIR];
  asum_t  as_nxt [NPAIR];
  err_t   err_r  [3];
  err_t   err_nxt [3];

  always_comb begin
    logic signed [59:0] pr;
    pr = '0;
    for (int p = 0; p < NPAIR; p++) begin
      for (int k = 0; k < 3; k++) begin
        pr = 60'(rd[k][A_ROW[p]]) * 60'(r[k][A_COL[p]]);
        xp_nxt[p][k] = pr[57:0];
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      as_nxt[p] = 60'(xp_r[p][0]) + 60'(xp_r[p][1]) + 60'(xp_r[p][2]);
    end
  end

  // shift by 35 folds in the divide by two
  always_comb begin
    logic signed [60:0] d;
    d = '0;
    for (int c = 0; c < 3; c++) begin
      d = 61'(as_r[2*c]) - 61'(as_r[2*c+1]);
      d = d + 61'sd17179869184;
      err_nxt[c] = sat16(d[60:35]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[S_XP]) begin
      xp_r <= xp_nxt;
    end
    if (ctl.ld[S_SUM]) begin
      as_r <= as_nxt;
    end
    if (ctl.ld[S_ERR]) begin
      err_r <= err_nxt;
    end
  end

  assign err = err_r;

endmodule

/* sv/so3aerc_rate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3aerc_rate
// Body rate command -gain*e: gain product, then rounding to Q14 and
// saturation into the output register.
// ----------------------------------------------------------------------------
module so3aerc_rate
  import so3aerc_pkg::*;
(
  input  logic     clk,
  input  stg_ctl_t ctl,
  input  gain_t    gain,
  input  err_t     err_in [3],
  output err_t     err_out [3],
  output rate_t    rate [3]
);

  gprod_t p_r    [3];
  gprod_t p_nxt  [3];
  err_t   e6_r   [3];
  err_t   e7_r   [3];
  rate_t  rc_r   [3];
  rate_t  rc_nxt [3];

  always_comb begin
    gprod_t g;
    gprod_t prod;
    g = {18'd0, gain};
    prod = '0;
    for (int c = 0; c < 3; c++) begin
      prod = g * 34'(err_in[c]);
      p_nxt[c] = -prod;
    end
  end

  always_comb begin
    gprod_t s;
    s = '0;
    for (int c = 0; c < 3; c++) begin
      s = p_r[c] + 34'sd128;
      rc_nxt[c] = sat24(s[33:8]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[S_GAIN]) begin
      p_r  <= p_nxt;
      e6_r <= err_in;
    end
    if (ctl.ld[S_OUT]) begin
      rc_r <= rc_nxt;
      e7_r <= e6_r;
    end
  end

  assign err_out = e7_r;
  assign rate    = rc_r;

endmodule

/* sv/so3_attitude_error_rate_command.sv */
`timescale 1ns / 1ps
// One transaction per cycle while out_ready does not stall the pipeline; seven
// register stages, each with its own valid bit, and a stage loads whenever it
// is empty or its successor moves.
// Reset (synchronous, rst_n low) clears all stage valid bits and sets
// rate_gain to 512 (2.0 in Q8.8); the data path registers are not reset.
// ----------------------------------------------------------------------------
// so3_attitude_error_rate_command
// Geometric attitude error between measured and reference quaternions and
// the proportional body rate command, as a seven-stage pipeline.
// ----------------------------------------------------------------------------
module so3_attitude_error_rate_command
  import so3aerc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_rate_gain,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_cur_qw,
  input  logic signed [15:0]  in_cur_qx,
  input  logic signed [15:0]  in_cur_qy,
  input  logic signed [15:0]  in_cur_qz,
  input  logic signed [15:0]  in_ref_qw,
  input  logic signed [15:0]  in_ref_qx,
  input  logic signed [15:0]  in_ref_qy,
  input  logic signed [15:0]  in_ref_qz,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_att_err_x,
  output logic signed [15:0]  out_att_err_y,
  output logic signed [15:0]  out_att_err_z,
  output logic signed [23:0]  out_rate_cmd_x,
  output logic signed [23:0]  out_rate_cmd_y,
  output logic signed [23:0]  out_rate_cmd_z
);

  gain_t           rate_gain_r, rate_gain_nxt;
  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] vin;
  stg_ctl_t        ctl;
  mat_t            r_cur, r_ref;
  err_t            err [3];
  err_t            err_o [3];
  rate_t           rate [3];

  // config register
  assign cfg_ready = 1'b1;
  assign rate_gain_nxt = (cfg_valid && cfg_ready) ? cfg_rate_gain : rate_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_gain_r <= GAIN_RST;
    end else begin
      rate_gain_r <= rate_gain_nxt;
    end
  end

  // per-stage ready chain
  always_comb begin
    rdy[S_OUT] = !v_r[S_OUT] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    vin    = {v_r[NSTG-2:0], in_valid};
    ctl.ld = rdy & vin;
    for (int k = 0; k < NSTG; k++) begin
      v_nxt[k] = rdy[k] ? vin[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[S_PROD];
  assign out_valid = v_r[S_OUT];

  so3aerc_quat_mat u_cur (
    .clk (clk),
    .ctl (ctl),
    .qw  (in_cur_qw),
    .qx  (in_cur_qx),
    .qy  (in_cur_qy),
    .qz  (in_cur_qz),
    .m   (r_cur)
  );

  so3aerc_quat_mat u_ref (
    .clk (clk),
    .ctl (ctl),
    .qw  (in_ref_qw),
    .qx  (in_ref_qx),
    .qy  (in_ref_qy),
    .qz  (in_ref_qz),
    .m   (r_ref)
  );

  so3aerc_err u_err (
    .clk (clk),
    .ctl (ctl),
    .r   (r_cur),
    .rd  (r_ref),
    .err (err)
  );

  so3aerc_rate u_rate (
    .clk     (clk),
    .ctl     (ctl),
    .gain    (rate_gain_r),
    .err_in  (err),
    .err_out (err_o),
    .rate    (rate)
  );

  assign out_att_err_x  = err_o[0];
  assign out_att_err_y  = err_o[1];
  assign out_att_err_z  = err_o[2];
  assign out_rate_cmd_x = rate[0];
  assign out_rate_cmd_y = rate[1];
  assign out_rate_cmd_z = rate[2];

  // an empty output stage never holds off new transactions
  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output stage");

  // a full pipeline under back pressure must stall the input
  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ready) |-> !in_ready)
    else $error("input accepted into a full stalled pipeline");

  a_accept_fill : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[S_PROD])
    else $error("accepted transaction lost at first stage");

  // rate command opposes the error (gain is unsigned)
  a_rate_sign : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_att_err_x[15]) |-> (out_rate_cmd_x[23] || out_rate_cmd_x == 24'sd0))
    else $error("rate command x has the sign of the error");

  a_rate_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_att_err_y == 16'sd0) |-> (out_rate_cmd_y == 24'sd0))
    else $error("nonzero rate command y for zero error");

endmodule
